[hw/rtl/rbb_pkg.sv]
package rbb_pkg;

  localparam int NYQ_W = 17;
  localparam int FREQ_W = 21;
  localparam int RES_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 17;
  localparam int CORDIC_STEPS = 30;
  localparam int HIST_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_NYQUIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd2;

  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [18:0] T60_MUL = 19'd488329;

  // Item queued between front and back: Qr resolved, clamped angle inputs.
  typedef struct packed {
    logic              clr;
    logic [23:0]       qr;
    logic [FREQ_W-1:0] fc;
    logic [NYQ_W-1:0]  nyq;
    logic              byp;
  } rbb_cmd_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    case (i)
      5'd0: atan_turn = 32'd536870912;
      5'd1: atan_turn = 32'd316933406;
      5'd2: atan_turn = 32'd167458907;
      5'd3: atan_turn = 32'd85004756;
      5'd4: atan_turn = 32'd42667331;
      5'd5: atan_turn = 32'd21354465;
      5'd6: atan_turn = 32'd10679838;
      5'd7: atan_turn = 32'd5340245;
      5'd8: atan_turn = 32'd2670163;
      5'd9: atan_turn = 32'd1335087;
      5'd10: atan_turn = 32'd667544;
      5'd11: atan_turn = 32'd333772;
      5'd12: atan_turn = 32'd166886;
      5'd13: atan_turn = 32'd83443;
      5'd14: atan_turn = 32'd41722;
      5'd15: atan_turn = 32'd20861;
      5'd16: atan_turn = 32'd10430;
      5'd17: atan_turn = 32'd5215;
      5'd18: atan_turn = 32'd2608;
      5'd19: atan_turn = 32'd1304;
      5'd20: atan_turn = 32'd652;
      5'd21: atan_turn = 32'd326;
      5'd22: atan_turn = 32'd163;
      5'd23: atan_turn = 32'd81;
      5'd24: atan_turn = 32'd41;
      5'd25: atan_turn = 32'd20;
      5'd26: atan_turn = 32'd10;
      5'd27: atan_turn = 32'd5;
      5'd28: atan_turn = 32'd3;
      5'd29: atan_turn = 32'd1;
      default: atan_turn = 32'd0;
    endcase
  endfunction

endpackage

[hw/rtl/rbb_if.sv]
interface rbb_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rbb_front.sv]
// Front: resolves Qr (decay-time mode via the F_MUL and F_T60 multiplies), clamps freq.
module rbb_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic [rbb_pkg::FREQ_W-1:0]   in_freq,
  input  logic [rbb_pkg::RES_W-1:0]    in_res,
  input  logic [rbb_pkg::NYQ_W-1:0]    nyquist_hz,
  input  logic                         bypass_enable,
  input  logic                         decay_time_mode,
  output logic                         q_valid,
  input  logic                         q_ready,
  output rbb_pkg::rbb_cmd_t            q_cmd,
  output logic [SAMPLE_BITS-1:0]       q_sample
);
  import rbb_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_T60, F_QR, F_OUT} fstate_t;
  fstate_t st_r;
  logic              kind_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic [FREQ_W-1:0] cf_r;
  logic [RES_W-1:0]  res_r;
  logic [44:0]       prod_r;
  logic [63:0]       t60_r;
  rbb_cmd_t          cmd_r;
  logic [NYQ_W-1:0]  nyq;
  logic [FREQ_W:0]   fmax;
  logic [FREQ_W-1:0] fc;
  logic [29:0]       qfull;

  always_comb begin
    nyq = (nyquist_hz == '0) ? NYQ_W'(1) : nyquist_hz;
    fmax = {nyq, 4'd0} - (FREQ_W + 1)'(1);
    fc = (cf_r == '0) ? FREQ_W'(1) : cf_r;
    if ({1'b0, fc} > fmax) fc = fmax[FREQ_W-1:0];
    qfull = 30'((t60_r + 64'h2_0000_0000) >> 34);
  end

  assign in_ready = (st_r == F_IDLE);
  assign q_valid = (st_r == F_OUT);
  assign q_cmd = cmd_r;
  assign q_sample = smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      case (st_r)
        F_IDLE: if (in_valid) begin
          kind_r <= in_kind;
          smp_r <= in_sample;
          cf_r <= in_freq;
          res_r <= in_res;
          st_r <= F_MUL;
        end
        F_MUL: begin
          prod_r <= 45'(cf_r) * 45'(res_r);
          st_r <= F_T60;
        end
        F_T60: begin
          t60_r <= 64'(prod_r) * 64'(T60_MUL);
          st_r <= F_QR;
        end
        F_QR: begin
          cmd_r.clr <= kind_r;
          cmd_r.fc <= fc;
          cmd_r.nyq <= nyq;
          cmd_r.byp <= bypass_enable;
          if (decay_time_mode)
            cmd_r.qr <= (qfull > 30'hFF_FFFF) ? 24'hFF_FFFF : qfull[23:0];
          else
            cmd_r.qr <= res_r;
          st_r <= F_OUT;
        end
        F_OUT: begin
          if (q_ready) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/rbb_back.sv]
// Back: angle division, CORDIC, coefficient divisions, MAC, history.
module rbb_back #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   c_valid,
  output logic                   c_ready,
  input  rbb_pkg::rbb_cmd_t      c_cmd,
  input  logic [SAMPLE_BITS-1:0] c_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample
);
  import rbb_pkg::*;

  localparam int DW = 64;
  localparam int CW = COEF_FRAC_BITS + 3;
  typedef enum logic [3:0] {
    B_IDLE, B_ANG, B_COR, B_FIN, B_SET, B_DA0, B_DB1, B_DB2, B_M0, B_M1, B_M2, B_WB,
    B_OUT
  } bstate_t;

  bstate_t st_r;
  rbb_cmd_t cmd_r;
  logic signed [SAMPLE_BITS-1:0] xn_r, x1_r, x2_r;
  logic signed [HIST_W-1:0] y1_r, y2_r;
  logic [SAMPLE_BITS-1:0] out_r;
  // shared restoring divider: remainder preloaded with the dividend's high
  // part (always below the divisor), low bits shifted in from dq_r
  logic [DW-1:0] dnum_r, dden_r, dq_r;
  logic [6:0]    dcnt_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic [4:0]    ci_r;
  logic          mir_r, b2neg_r, cneg_r;
  logic [31:0]   sin_r, cos_r;
  logic signed [CW-1:0] a0_r, b1_r, b2_r;
  logic signed [95:0] acc_r;
  logic [DW:0]   rsh;
  logic [DW-1:0] qq2, den;
  logic [55:0]   na0;
  logic [57:0]   nb1;
  logic [47:0]   nb2;
  logic signed [33:0] ysh, xsh;
  logic signed [95:0] yn;
  logic signed [HIST_W-1:0] ysat;
  logic qzero;

  assign qzero = (cmd_r.qr == '0);
  assign qq2 = DW'({cmd_r.qr, 23'd0});
  assign den = qq2 + DW'(sin_r);
  assign na0 = 56'(sin_r) * 56'(cmd_r.qr);
  assign nb1 = 58'({cos_r, 2'b0}) * 58'(cmd_r.qr);
  assign nb2 = b2neg_r ? 48'(qq2 - DW'(sin_r)) : 48'(DW'(sin_r) - qq2);
  assign rsh = {dnum_r, dq_r[DW-1]};
  assign ysh = cy_r >>> ci_r;
  assign xsh = cx_r >>> ci_r;
  assign c_ready = (st_r == B_IDLE);
  assign out_valid = (st_r == B_OUT);
  assign out_sample = out_r;

  always_comb begin
    yn = (acc_r + (96'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (yn > 96'sh7FFF_FFFF) ysat = 32'sh7FFF_FFFF;
    else if (yn < -96'sh8000_0000) ysat = -32'sh8000_0000;
    else ysat = yn[HIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      x1_r <= '0; x2_r <= '0; y1_r <= '0; y2_r <= '0;
    end else begin
      case (st_r)
        B_IDLE: if (c_valid) begin
          cmd_r <= c_cmd;
          xn_r <= c_sample;
          if (c_cmd.clr) begin
            x1_r <= '0; x2_r <= '0; y1_r <= '0; y2_r <= '0;
          end else begin
            // angle = (fc<<27)/nyq; fc>>4 < nyq, so 4 + 27 steps
            dnum_r <= DW'(c_cmd.fc >> 4);
            dq_r <= {c_cmd.fc[3:0], 60'd0};
            dden_r <= DW'(c_cmd.nyq);
            dcnt_r <= 7'd31;
            st_r <= B_ANG;
          end
        end
        B_ANG, B_DA0, B_DB1, B_DB2: begin
          if (dcnt_r != '0) begin
            if (rsh >= {1'b0, dden_r}) begin
              dnum_r <= DW'(rsh - {1'b0, dden_r});
              dq_r <= {dq_r[DW-2:0], 1'b1};
            end else begin
              dnum_r <= rsh[DW-1:0];
              dq_r <= {dq_r[DW-2:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 7'd1;
          end else begin
            case (st_r)
              B_ANG: begin
                mir_r <= dq_r[31:0] > 32'h4000_0000;
                cz_r <= (dq_r[31:0] > 32'h4000_0000) ?
                        34'(32'h8000_0000 - dq_r[31:0]) : 34'(dq_r[31:0]);
                cx_r <= $signed(CORDIC_GAIN);
                cy_r <= '0;
                ci_r <= '0;
                st_r <= B_COR;
              end
              B_DA0: begin
                a0_r <= CW'(dq_r);
                // b1 = 4|cos|Qr * 2^(CF-8) / den; high part >> 10 stays below den
                dnum_r <= DW'(nb1 >> 10);
                dq_r <= {nb1[9:0], 54'd0};
                dcnt_r <= 7'(10 + COEF_FRAC_BITS - 8);
                st_r <= B_DB1;
              end
              B_DB1: begin
                b1_r <= cneg_r ? -CW'(dq_r) : CW'(dq_r);
                // b2 = |sin - 2qq| * 2^CF / den
                dnum_r <= DW'(nb2 >> 1);
                dq_r <= {nb2[0], 63'd0};
                dcnt_r <= 7'(1 + COEF_FRAC_BITS);
                st_r <= B_DB2;
              end
              default: begin
                b2_r <= b2neg_r ? -CW'(dq_r) : CW'(dq_r);
                st_r <= B_M0;
              end
            endcase
          end
        end
        B_COR: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - ysh; cy_r <= cy_r + xsh; cz_r <= cz_r - 34'(atan_turn(ci_r));
          end else begin
            cx_r <= cx_r + ysh; cy_r <= cy_r - xsh; cz_r <= cz_r + 34'(atan_turn(ci_r));
          end
          ci_r <= ci_r + 5'd1;
          if (ci_r == 5'(CORDIC_STEPS - 1)) st_r <= B_FIN;
        end
        B_FIN: begin
          // clamp sin/cos; zero Q takes the limit coefficients
          sin_r <= cy_r[33] ? 32'd0 : (cy_r > 34'sh4000_0000 ? 32'h4000_0000 : cy_r[31:0]);
          if (cx_r > 34'sh4000_0000) cos_r <= 32'h4000_0000;
          else if (cx_r < -34'sh4000_0000) cos_r <= 32'h4000_0000;
          else cos_r <= cx_r[33] ? 32'(-cx_r) : cx_r[31:0];
          cneg_r <= mir_r ^ cx_r[33];
          st_r <= qzero ? B_M0 : B_SET;
          if (qzero) begin
            a0_r <= '0; b1_r <= '0;
            b2_r <= CW'(1) << COEF_FRAC_BITS;
          end
        end
        B_SET: begin
          // a0 = sin*Qr * 2^(CF-8) / den; high part >> 7 stays below den
          dnum_r <= DW'(na0 >> 7);
          dq_r <= {na0[6:0], 57'd0};
          dcnt_r <= 7'(7 + COEF_FRAC_BITS - 8);
          dden_r <= den;
          b2neg_r <= (qq2 > DW'(sin_r));
          st_r <= B_DA0;
        end
        B_M0: begin
          acc_r <= 96'(a0_r) * 96'(96'(xn_r) - 96'(x2_r));
          st_r <= B_M1;
        end
        B_M1: begin
          acc_r <= acc_r + 96'(b1_r) * 96'(y1_r);
          st_r <= B_M2;
        end
        B_M2: begin
          acc_r <= acc_r + 96'(b2_r) * 96'(y2_r);
          st_r <= B_WB;
        end
        B_WB: begin
          x2_r <= x1_r; x1_r <= xn_r; y2_r <= y1_r; y1_r <= ysat;
          if (cmd_r.byp || qzero) out_r <= xn_r;
          else if (ysat > HIST_W'(2**(SAMPLE_BITS-1) - 1))
            out_r <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          else if (ysat < -$signed(HIST_W'(2**(SAMPLE_BITS-1))))
            out_r <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
          else out_r <= ysat[SAMPLE_BITS-1:0];
          st_r <= B_OUT;
        end
        B_OUT: begin
          if (out_ready) st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/resonant_bandpass_biquad_core.sv]
// channel | dir | payload
// in      | in  | kind, sample_in, centre_freq, resonance_value
// out     | out | sample_out
// cfg     | in  | index, data (nyquist_hz, bypass_enable, decay_time_mode)
// The back end takes no new word until the last one has left B_OUT. The
// shared bit-serial divider (angle 31, a0 23, b1 26, b2 25 steps) does most
// of the work, plus 30 CORDIC steps and three MACs. A zero-Q word skips the
// coefficient divisions. Clear words only reset the history, with no output.
// rst_n is synchronous; it clears the history and restores register defaults.
// Front and back each stall alone.
module resonant_bandpass_biquad_core #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input logic clk,
  input logic rst_n,
  rbb_if.sink   in_ch,
  rbb_if.source out_ch,
  rbb_if.sink   cfg_ch
);
  import rbb_pkg::*;

  logic [NYQ_W-1:0] nyq_r;
  logic byp_r, dec_r;
  logic qv, qr;
  rbb_cmd_t qc;
  logic [SAMPLE_BITS-1:0] qs;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nyq_r <= NYQ_W'(24000); byp_r <= 1'b0; dec_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[CFG_IDX_W+CFG_DATA_W-1:CFG_DATA_W])
        REG_NYQUIST: nyq_r <= cfg_ch.data[NYQ_W-1:0];
        REG_BYPASS: byp_r <= cfg_ch.data[0];
        REG_DECAY: dec_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  rbb_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_kind(in_ch.data[0]),
    .in_sample(in_ch.data[SAMPLE_BITS:1]),
    .in_freq(in_ch.data[SAMPLE_BITS+FREQ_W:SAMPLE_BITS+1]),
    .in_res(in_ch.data[SAMPLE_BITS+FREQ_W+RES_W:SAMPLE_BITS+FREQ_W+1]),
    .nyquist_hz(nyq_r), .bypass_enable(byp_r), .decay_time_mode(dec_r),
    .q_valid(qv), .q_ready(qr), .q_cmd(qc), .q_sample(qs)
  );

  rbb_back #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_back (
    .clk, .rst_n,
    .c_valid(qv), .c_ready(qr), .c_cmd(qc), .c_sample(qs),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_sample(out_ch.data[SAMPLE_BITS-1:0])
  );
endmodule

[test/rbb_checker.sv]
module rbb_checker (
  input  logic  clk,
  input  logic  rst_n,
  rbb_if        in_ch,
  rbb_if        out_ch,
  rbb_if        cfg_ch,
  output int    errors,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam int SBITS = 24;
  localparam int CFRAC = 24;

  localparam longint ATAN_TAB [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  logic [NYQ_W-1:0] nyq_reg;
  logic             bypass_reg;
  logic             decay_reg;
  longint           x_d1, x_d2, y_d1, y_d2;
  logic [SBITS-1:0] sample_fifo [$];

  assign pending = sample_fifo.size();

  function automatic longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // floor(num * 2^bits / den), long division
  function automatic longint unsigned div_frac(longint unsigned num, longint unsigned den,
                                               int bits);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    for (int i = 0; i < bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic void rotate(longint unsigned turns, output longint s, output longint c);
    bit     mirror;
    longint x, y, z, t;
    mirror = 0;
    x = 652032874;
    y = 0;
    if (turns > (64'd1 << 30)) begin
      turns = (64'd1 << 31) - turns;
      mirror = 1;
    end
    z = longint'(turns);
    for (int i = 0; i < 30; i++) begin
      t = x;
      if (z >= 0) begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - ATAN_TAB[i];
      end else begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + ATAN_TAB[i];
      end
    end
    if (y < 0) y = 0;
    if (y > (longint'(1) <<< 30)) y = longint'(1) <<< 30;
    if (x > (longint'(1) <<< 30)) x = longint'(1) <<< 30;
    if (x < -(longint'(1) <<< 30)) x = -(longint'(1) <<< 30);
    s = y;
    c = mirror ? -x : x;
  endfunction

  // One filter word: returns the output sample and advances the history.
  function automatic logic [SBITS-1:0] bandpass_sample(logic [SBITS-1:0] smp,
                                                       logic [FREQ_W-1:0] cf,
                                                       logic [RES_W-1:0] res);
    longint unsigned qr, nyq, fmax, fc, qq, den, ac;
    longint          xn, s, c, a0, b1, b2, acc, yn, o;
    bit              qzero;
    xn = longint'($signed(smp));
    if (decay_reg) begin
      qr = (longint'(cf) * longint'(res) * 64'd488329 + (64'd1 << 33)) >> 34;
      if (qr > 64'hFFFFFF) qr = 64'hFFFFFF;
    end else begin
      qr = res;
    end
    qzero = (qr == 0);
    nyq = (nyq_reg == 0) ? 1 : nyq_reg;
    fmax = nyq * 16 - 1;
    fc = (cf < 1) ? 1 : cf;
    if (fc > fmax) fc = fmax;
    rotate((fc << 27) / nyq, s, c);
    if (qzero) begin
      a0 = 0;
      b1 = 0;
      b2 = longint'(1) <<< CFRAC;
    end else begin
      qq = qr << 22;
      den = 2 * qq + s;
      ac = (c < 0) ? -c : c;
      a0 = div_frac(s * qr, den, CFRAC - 8);
      b1 = div_frac(4 * ac * qr, den, CFRAC - 8);
      if (c < 0) b1 = -b1;
      if (s >= 2 * qq) b2 = div_frac(s - 2 * qq, den, CFRAC);
      else b2 = -longint'(div_frac(2 * qq - s, den, CFRAC));
    end
    acc = a0 * (xn - x_d2) + b1 * y_d1 + b2 * y_d2;
    yn = (acc + (longint'(1) <<< (CFRAC - 1))) >>> CFRAC;
    yn = clip(yn, HIST_W);
    o = (bypass_reg || qzero) ? xn : clip(yn, SBITS);
    x_d2 = x_d1;
    x_d1 = xn;
    y_d2 = y_d1;
    y_d1 = yn;
    return o[SBITS-1:0];
  endfunction

  task automatic report(string what, logic [SBITS-1:0] got, logic [SBITS-1:0] want);
    $display("%0t: MISMATCH %s got %0d want %0d", $realtime, what, $signed(got),
             $signed(want));
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      nyq_reg <= 17'd24000;
      bypass_reg <= 1'b0;
      decay_reg <= 1'b0;
      x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0;
      sample_fifo.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data[CFG_DATA_W +: CFG_IDX_W])
          REG_NYQUIST: nyq_reg <= cfg_ch.data[NYQ_W-1:0];
          REG_BYPASS:  bypass_reg <= cfg_ch.data[0];
          REG_DECAY:   decay_reg <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data[0]) begin
          x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0;
        end else begin
          sample_fifo.push_back(bandpass_sample(in_ch.data[24:1], in_ch.data[45:25],
                                                in_ch.data[69:46]));
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sample_fifo.size() == 0) report("unexpected word", out_ch.data, '0);
        else begin
          logic [SBITS-1:0] want;
          want = sample_fifo.pop_front();
          if (out_ch.data !== want) report("sample_out", out_ch.data, want);
        end
      end
    end
  end
endmodule

[test/resonant_bandpass_biquad_core_tb.sv]
module resonant_bandpass_biquad_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3; // unmapped index, must be ignored
  localparam int DRAIN_CYCLES = 400;                  // > one filter word latency
  localparam int STALL_LIMIT = 50000;                 // cycles with no handshake at all

  logic clk, rst_n;
  int   errors, pending;
  int   idle_pct, stall_pct;
  int   quiet_cycles;

  rbb_if #(.W(70)) in_ch ();
  rbb_if #(.W(24)) out_ch ();
  rbb_if #(.W(CFG_IDX_W + CFG_DATA_W)) cfg_ch ();

  resonant_bandpass_biquad_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rbb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side back-pressure, rate set per phase.
  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: abort if no channel moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drop the input valid and wait until every predicted sample came back,
  // plus enough cycles for a trailing clear word to finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= {idx, val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high across back-to-back words; it only drops for a gap.
  task automatic send_word(logic kind, logic [23:0] smp, logic [FREQ_W-1:0] cf,
                           logic [RES_W-1:0] res);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {res, cf, smp, kind};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Mostly musical frequencies and Q values, with edges and occasional clear words mixed in.
  task automatic random_word();
    logic [FREQ_W-1:0] cf;
    logic [RES_W-1:0]  res;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_word(1'b1, 24'($urandom), 21'($urandom), 24'($urandom));
      return;
    end
    case ($urandom_range(9))
      0: cf = 21'($urandom_range(1536000));
      1: cf = 21'($urandom_range(3));
      2: cf = 21'($urandom_range(1536000, 1500000));
      default: cf = 21'($urandom_range(320000, 320));
    endcase
    case ($urandom_range(9))
      0: res = 24'($urandom);
      1: res = 24'($urandom_range(3));
      2: res = 24'($urandom_range(16777215, 16000000));
      default: res = 24'($urandom_range(12800, 128));
    endcase
    send_word(1'b0, 24'($urandom), cf, res);
  endtask

  initial begin
    int nyq_pick [5];
    nyq_pick = '{24000, 1000, 96000, 22050, 48000};
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, clamps, zero Q, clear.
    send_word(1'b0, 24'h7FFFFF, 21'd16000, 24'd256);
    send_word(1'b0, 24'h800000, 21'd16000, 24'd256);
    send_word(1'b0, 24'h7FFFFF, 21'd0, 24'd2560);
    send_word(1'b0, 24'h800000, 21'd1536000, 24'd2560);
    send_word(1'b0, 24'h7FFFFF, 21'd383999, 24'd64);
    send_word(1'b0, 24'h123456, 21'd192000, 24'd0);
    send_word(1'b0, 24'hFFFFFF, 21'd1, 24'hFFFFFF);
    send_word(1'b0, 24'h000001, 21'd192000, 24'd1);
    send_word(1'b1, 24'h0, 21'd0, 24'd0);
    send_word(1'b0, 24'h400000, 21'd80000, 24'd3000);
    settle();
    write_reg(REG_DECAY, 17'd1);
    write_reg(REG_SPARE, 17'h1FFFF);
    send_word(1'b0, 24'h7FFFFF, 21'd1536000, 24'hFFFFFF);
    send_word(1'b0, 24'h800000, 21'd0, 24'd50000);
    send_word(1'b0, 24'h200000, 21'd16, 24'd1);
    send_word(1'b0, 24'h600000, 21'd16000, 24'd25600);
    settle();
    write_reg(REG_BYPASS, 17'd1);
    write_reg(REG_NYQUIST, 17'd1000);
    send_word(1'b0, 24'h7FFFFF, 21'd15999, 24'd300);
    send_word(1'b0, 24'h800000, 21'd100, 24'd300);
    settle();
    write_reg(REG_NYQUIST, 17'd96000);
    write_reg(REG_BYPASS, 17'd0);
    write_reg(REG_DECAY, 17'd0);
    send_word(1'b0, 24'h7FFFFF, 21'd1535999, 24'd500);
    send_word(1'b0, 24'h800000, 21'd8000, 24'd500);

    // Random phases: idling pattern rotates, registers change between phases.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_reg(REG_NYQUIST, (ph < 5) ? 17'(nyq_pick[ph]) : 17'($urandom_range(96000, 1000)));
      write_reg(REG_BYPASS, 17'(ph == 3 || ph == 6));
      write_reg(REG_DECAY, 17'(ph[0]));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      for (int n = 0; n < 185; n++) begin
        if (n == 90) begin
          // hold off until the block has fully caught up
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_word();
      end
    end

    settle();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
